// ===== src/ftzs_pkg.sv =====
// ----------------------------------------------------------------------------
// ftzs_pkg
// shared widths, codes and handshake types of the focal table zoom select block
// ----------------------------------------------------------------------------
package ftzs_pkg;

    localparam int FOCAL_W = 10;
    localparam int ZOOM_W  = 16;
    localparam int SENS_W  = 16;
    localparam int DIST_W  = 18;
    localparam int SIZE_W  = 16;
    localparam int SCALE_W = 4;

    // product widths of the demand terms
    localparam int NUM_W = SENS_W + DIST_W + 4;      // sensor * distance * 16
    localparam int SS_W  = SIZE_W + SCALE_W;         // size * scale
    localparam int UM_W  = 10;
    localparam int DEN_W = SS_W + UM_W;              // size * scale * 1000
    // demand quotient, saturated; wide enough to exceed any focal in q4
    localparam int Q_W   = FOCAL_W + 5;

    localparam logic [ZOOM_W-1:0] ZOOM_FLOOR = ZOOM_W'(8);
    localparam logic [UM_W-1:0]   UM_PER_MM  = UM_W'(1000);

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] CFG_SENSOR_W = 2'd0;
    localparam logic [1:0] CFG_SENSOR_H = 2'd1;
    localparam logic [1:0] CFG_ENTRIES  = 2'd2;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quot;
    } div_rsp_t;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_NUM   = 8'b0000_0010,
        ST_DEN1  = 8'b0000_0100,
        ST_DEN2  = 8'b0000_1000,
        ST_DIV   = 8'b0001_0000,
        ST_LAST  = 8'b0010_0000,
        ST_SCAN  = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

endpackage

// ===== src/ftzs_div.sv =====
// ----------------------------------------------------------------------------
// ftzs_div
// restoring divider, one quotient bit per cycle, saturating quotient
// ----------------------------------------------------------------------------
module ftzs_div (
    input  logic              clk,
    input  logic              rst_n,
    input  ftzs_pkg::div_req_t req,
    output ftzs_pkg::div_rsp_t rsp
);
    import ftzs_pkg::*;

    localparam int DSR_W = DEN_W + Q_W;
    localparam int CNT_W = $clog2(Q_W + 1);
    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(Q_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [DSR_W-1:0] dsr_reg, dsr_next;
    logic [Q_W-1:0]   q_reg, q_next;
    logic             ovf_reg, ovf_next;
    logic             ge;

    assign ge = DSR_W'(rem_reg) >= dsr_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_TOP;
            rem_next  = req.num;
            dsr_next  = {req.den, {Q_W{1'b0}}};
            q_next    = '0;
            ovf_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            // top step only checks for a quotient that does not fit
            if (cnt_reg == CNT_TOP)
            begin
                ovf_next = ge;
            end
            else if (ge)
            begin
                rem_next = rem_reg - dsr_reg[NUM_W-1:0];
            end
            q_next   = {q_reg[Q_W-2:0], ge & (cnt_reg != CNT_TOP)};
            dsr_next = dsr_reg >> 1;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = ovf_reg ? {Q_W{1'b1}} : q_reg;

endmodule

// ===== src/focal_table_zoom_select_core.sv =====
// ----------------------------------------------------------------------------
// focal_table_zoom_select_core
// picks a zoom code and focal length from a loaded lens table per object size
// ----------------------------------------------------------------------------
// A load item (tuser 0) writes one table entry. A query
// item (tuser 1) computes the q4 focal demand for width and height, each
// through one shared multiplier (three products) and a bit-serial divider
// (sixteen steps), then walks the table one entry per cycle through its
// registered read port. A query with an unknown size skips the demand and
// goes straight to the result.
// The input side is not ready while a query is in work; a finished result
// sits in the output register so the next item can be taken meanwhile.
module focal_table_zoom_select_core #(
    parameter int TABLE_DEPTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    // entry_index[2:0], entry_focal_mm[12:3], entry_zoom_code[28:13],
    // distance_mm[46:29], object_width_mm[62:47], object_height_mm[78:63],
    // scale_divisor[82:79]
    input  logic [87:0] s_tdata,
    // command[0]
    input  logic        s_tuser,
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    // zoom_code[15:0], focus_mm[25:16]
    output logic [31:0] m_tdata,
    // size_unknown[0]
    output logic        m_tuser
);
    import ftzs_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [7:0] DEPTH8 = 8'(TABLE_DEPTH);

    // input fields
    logic [2:0]         in_idx;
    logic [FOCAL_W-1:0] in_focal;
    logic [ZOOM_W-1:0]  in_zoom;
    logic [DIST_W-1:0]  in_dist;
    logic [SIZE_W-1:0]  in_ow;
    logic [SIZE_W-1:0]  in_oh;
    logic [SCALE_W-1:0] in_scale;

    assign in_idx   = s_tdata[2:0];
    assign in_focal = s_tdata[12:3];
    assign in_zoom  = s_tdata[28:13];
    assign in_dist  = s_tdata[46:29];
    assign in_ow    = s_tdata[62:47];
    assign in_oh    = s_tdata[78:63];
    assign in_scale = s_tdata[82:79];

    // configuration registers
    logic [SENS_W-1:0] sens_w_reg;
    logic [SENS_W-1:0] sens_h_reg;
    logic [3:0]        entries_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sens_w_reg  <= SENS_W'(3750);
            sens_h_reg  <= SENS_W'(3750);
            entries_reg <= 4'd2;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_SENSOR_W: sens_w_reg  <= cfg_data;
                CFG_SENSOR_H: sens_h_reg  <= cfg_data;
                CFG_ENTRIES:  entries_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // table memory
    logic [FOCAL_W-1:0] focal_mem [TABLE_DEPTH];
    logic [ZOOM_W-1:0]  zoom_mem  [TABLE_DEPTH];
    logic [FOCAL_W-1:0] rd_focal_reg;
    logic [ZOOM_W-1:0]  rd_zoom_reg;
    logic [IW-1:0]      mem_addr;
    logic               load_we;

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            focal_mem[IW'(in_idx)] <= in_focal;
            zoom_mem[IW'(in_idx)]  <= in_zoom;
        end
        rd_focal_reg <= focal_mem[mem_addr];
        rd_zoom_reg  <= zoom_mem[mem_addr];
    end

    // sequencer state
    state_t             state_reg, state_next;
    logic               axis_reg, axis_next;
    logic [SCALE_W-1:0] scale_reg, scale_next;
    logic [DIST_W-1:0]  dist_reg, dist_next;
    logic [SIZE_W-1:0]  ow_reg, ow_next;
    logic [SIZE_W-1:0]  oh_reg, oh_next;
    logic [IW-1:0]      n_last_reg, n_last_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [SS_W-1:0]    ss_reg, ss_next;
    logic [Q_W-1:0]     d_reg, d_next;
    logic [IW-1:0]      scan_reg, scan_next;
    logic [FOCAL_W-1:0] prev_f_reg, prev_f_next;
    logic [ZOOM_W-1:0]  prev_z_reg, prev_z_next;
    logic [FOCAL_W-1:0] wf_reg, wf_next;
    logic [ZOOM_W-1:0]  wz_reg, wz_next;
    logic [ZOOM_W-1:0]  res_zoom_reg, res_zoom_next;
    logic [FOCAL_W-1:0] res_focus_reg, res_focus_next;
    logic               res_unk_reg, res_unk_next;
    logic [FOCAL_W-1:0] last_focus_reg, last_focus_next;
    logic               out_valid_reg, out_valid_next;
    logic [ZOOM_W-1:0]  out_zoom_reg, out_zoom_next;
    logic [FOCAL_W-1:0] out_focus_reg, out_focus_next;
    logic               out_unk_reg, out_unk_next;

    // shared multiplier
    logic [SS_W-1:0]          mul_a;
    logic [DIST_W-1:0]        mul_b;
    logic [SS_W+DIST_W-1:0]   mul_p;

    assign mul_p = mul_a * mul_b;

    // divider
    div_req_t div_req;
    div_rsp_t div_rsp;

    ftzs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    logic               accept;
    logic [7:0]         n_ext;
    logic               axis_done;
    logic [ZOOM_W-1:0]  axis_z;
    logic [FOCAL_W-1:0] axis_f;
    logic [ZOOM_W-1:0]  min_z;
    logic [FOCAL_W-1:0] min_f;
    logic [Q_W-1:0]     lo_q4;
    logic [Q_W-1:0]     hi_q4;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign load_we  = accept & (s_tuser == CMD_LOAD) & ({5'b0, in_idx} < DEPTH8);

    assign lo_q4 = {1'b0, prev_f_reg, 4'b0};
    assign hi_q4 = {1'b0, rd_focal_reg, 4'b0};

    always_comb
    begin
        // entries in use, kept between one and the table depth
        n_ext = {4'b0, entries_reg};
        if (n_ext == 8'd0)
        begin
            n_ext = 8'd1;
        end
        if (n_ext > DEPTH8)
        begin
            n_ext = DEPTH8;
        end
    end

    assign min_z = (wz_reg < axis_z) ? wz_reg : axis_z;
    assign min_f = (wf_reg < axis_f) ? wf_reg : axis_f;

    always_comb
    begin
        state_next      = state_reg;
        axis_next       = axis_reg;
        scale_next      = scale_reg;
        dist_next       = dist_reg;
        ow_next         = ow_reg;
        oh_next         = oh_reg;
        n_last_next     = n_last_reg;
        num_next        = num_reg;
        ss_next         = ss_reg;
        d_next          = d_reg;
        scan_next       = scan_reg;
        prev_f_next     = prev_f_reg;
        prev_z_next     = prev_z_reg;
        wf_next         = wf_reg;
        wz_next         = wz_reg;
        res_zoom_next   = res_zoom_reg;
        res_focus_next  = res_focus_reg;
        res_unk_next    = res_unk_reg;
        last_focus_next = last_focus_reg;
        out_zoom_next   = out_zoom_reg;
        out_focus_next  = out_focus_reg;
        out_unk_next    = out_unk_reg;
        out_valid_next  = out_valid_reg & ~m_tready;
        mem_addr        = '0;
        mul_a           = '0;
        mul_b           = '0;
        div_req.start   = 1'b0;
        div_req.num     = num_reg;
        div_req.den     = mul_p[DEN_W-1:0];
        axis_done       = 1'b0;
        axis_z          = ZOOM_FLOOR;
        axis_f          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && s_tuser == CMD_QUERY)
                begin
                    dist_next   = in_dist;
                    ow_next     = in_ow;
                    oh_next     = in_oh;
                    scale_next  = (in_scale == '0) ? SCALE_W'(1) : in_scale;
                    n_last_next = IW'(n_ext - 8'd1);
                    axis_next   = 1'b0;
                    if (in_ow == '0 || in_oh == '0)
                    begin
                        res_zoom_next  = ZOOM_FLOOR;
                        res_focus_next = last_focus_reg;
                        res_unk_next   = 1'b1;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_NUM;
                    end
                end
            end
            ST_NUM:
            begin
                mul_a      = SS_W'(axis_reg ? sens_h_reg : sens_w_reg);
                mul_b      = dist_reg;
                num_next   = {mul_p[SENS_W+DIST_W-1:0], 4'b0};
                state_next = ST_DEN1;
            end
            ST_DEN1:
            begin
                mul_a      = SS_W'(axis_reg ? oh_reg : ow_reg);
                mul_b      = DIST_W'(scale_reg);
                ss_next    = mul_p[SS_W-1:0];
                state_next = ST_DEN2;
            end
            ST_DEN2:
            begin
                mul_a         = ss_reg;
                mul_b         = DIST_W'(UM_PER_MM);
                div_req.start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    d_next     = div_rsp.quot;
                    mem_addr   = n_last_reg;
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                // demand at or beyond the last entry takes the last entry
                if (d_reg >= hi_q4)
                begin
                    axis_done = 1'b1;
                    axis_z    = rd_zoom_reg;
                    axis_f    = rd_focal_reg;
                end
                else if (n_last_reg == '0)
                begin
                    axis_done = 1'b1;
                end
                else
                begin
                    mem_addr   = '0;
                    scan_next  = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                prev_f_next = rd_focal_reg;
                prev_z_next = rd_zoom_reg;
                scan_next   = scan_reg + IW'(1);
                if (scan_reg != n_last_reg)
                begin
                    mem_addr = scan_reg + IW'(1);
                end
                if (scan_reg != '0 && d_reg >= lo_q4 && d_reg <= hi_q4)
                begin
                    axis_done = 1'b1;
                    axis_z    = prev_z_reg;
                    axis_f    = prev_f_reg;
                end
                else if (scan_reg == n_last_reg)
                begin
                    axis_done = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_zoom_next   = res_zoom_reg;
                    out_focus_next  = res_focus_reg;
                    out_unk_next    = res_unk_reg;
                    last_focus_next = res_focus_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (axis_done)
        begin
            if (!axis_reg)
            begin
                wz_next    = axis_z;
                wf_next    = axis_f;
                axis_next  = 1'b1;
                state_next = ST_NUM;
            end
            else
            begin
                res_zoom_next  = (min_z < ZOOM_FLOOR) ? ZOOM_FLOOR : min_z;
                res_focus_next = min_f;
                res_unk_next   = 1'b0;
                state_next     = ST_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            axis_reg       <= 1'b0;
            last_focus_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            axis_reg       <= axis_next;
            last_focus_reg <= last_focus_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scale_reg     <= scale_next;
        dist_reg      <= dist_next;
        ow_reg        <= ow_next;
        oh_reg        <= oh_next;
        n_last_reg    <= n_last_next;
        num_reg       <= num_next;
        ss_reg        <= ss_next;
        d_reg         <= d_next;
        scan_reg      <= scan_next;
        prev_f_reg    <= prev_f_next;
        prev_z_reg    <= prev_z_next;
        wf_reg        <= wf_next;
        wz_reg        <= wz_next;
        res_zoom_reg  <= res_zoom_next;
        res_focus_reg <= res_focus_next;
        res_unk_reg   <= res_unk_next;
        out_zoom_reg  <= out_zoom_next;
        out_focus_reg <= out_focus_next;
        out_unk_reg   <= out_unk_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_focus_reg, out_zoom_reg};
    assign m_tuser  = out_unk_reg;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// checks focal_table_zoom_select_core against a cycle-free predictor of its
// table loads and per-axis zoom selection, under random stalls on both sides
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ftzs_pkg::*;

    localparam int DEPTH         = 8;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 106;
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int REPORT_LIMIT  = 10;
    localparam longint unsigned MAX_DIST = (64'd1 << DIST_W) - 1;

    // index past the register list, must be ignored
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    localparam int SEED_FOCAL [DEPTH] = '{0, 12, 25, 50, 100, 200, 500, 1023};
    localparam int SEED_ZOOM  [DEPTH] = '{0, 100, 500, 1000, 2000, 4000, 30000, 65535};

    typedef struct packed {
        logic               cmd;
        logic [2:0]         idx;
        logic [FOCAL_W-1:0] efocal;
        logic [ZOOM_W-1:0]  ezoom;
        logic [DIST_W-1:0]  dist_mm;
        logic [SIZE_W-1:0]  wsize;
        logic [SIZE_W-1:0]  hsize;
        logic [SCALE_W-1:0] scale;
    } lens_item_t;

    typedef struct packed {
        logic [ZOOM_W-1:0]  zoom;
        logic [FOCAL_W-1:0] focus;
        logic               unknown;
    } zoom_result_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [15:0] cfg_data  = 16'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    // predicted block state
    logic [FOCAL_W-1:0] lens_focal [DEPTH];
    logic [ZOOM_W-1:0]  lens_zoom  [DEPTH];
    logic [FOCAL_W-1:0] held_focus = '0;
    logic [SENS_W-1:0]  sens_w     = 16'd3750;
    logic [SENS_W-1:0]  sens_h     = 16'd3750;
    logic [3:0]         entry_cfg  = 4'd2;

    // table contents as queued, used only to aim queries
    int unsigned plan_focal [DEPTH];

    lens_item_t   pending_items[$];
    zoom_result_t expected_results[$];
    lens_item_t   offer       = '0;
    bit           offer_live  = 1'b0;
    int           send_gap    = 0;
    int           take_gap    = 0;
    int           in_flight   = 0;
    int           fault_count = 0;
    int           cycle_count = 0;
    bit           calm        = 1'b0;

    focal_table_zoom_select_core #(
        .TABLE_DEPTH (DEPTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int live_entries(input logic [3:0] v);
        if (v == 4'd0)
            return 1;
        if (v > DEPTH)
            return DEPTH;
        return int'(v);
    endfunction

    // q4 focal demand, truncated
    function automatic logic [63:0] focal_demand(input logic [SENS_W-1:0] sensor,
                                                 input logic [DIST_W-1:0] dist_mm,
                                                 input logic [SIZE_W-1:0] size,
                                                 input logic [SCALE_W-1:0] scale);
        return (64'(sensor) * 64'(dist_mm) * 64'd16) /
               (64'(UM_PER_MM) * 64'(size) * 64'(scale));
    endfunction

    function automatic void pick_entry(input logic [63:0] d, input int n,
                                       output logic [ZOOM_W-1:0] z,
                                       output logic [FOCAL_W-1:0] f);
        z = ZOOM_FLOOR;
        f = '0;
        if (d >= (64'(lens_focal[n-1]) << 4))
        begin
            z = lens_zoom[n-1];
            f = lens_focal[n-1];
            return;
        end
        for (int i = 0; i + 1 < n; i++)
        begin
            if (d >= (64'(lens_focal[i]) << 4) && d <= (64'(lens_focal[i+1]) << 4))
            begin
                z = lens_zoom[i];
                f = lens_focal[i];
                return;
            end
        end
    endfunction

    // applies one accepted item; returns 1 when it yields a result
    function automatic bit predict_item(input lens_item_t it, output zoom_result_t res);
        logic [SCALE_W-1:0] sc;
        logic [ZOOM_W-1:0]  wz, hz;
        logic [FOCAL_W-1:0] wf, hf;
        int n;
        res = '0;
        if (it.cmd == CMD_LOAD)
        begin
            lens_focal[it.idx] = it.efocal;
            lens_zoom[it.idx]  = it.ezoom;
            return 1'b0;
        end
        sc = (it.scale == '0) ? SCALE_W'(1) : it.scale;
        if (it.wsize == '0 || it.hsize == '0)
        begin
            res.zoom    = ZOOM_FLOOR;
            res.focus   = held_focus;
            res.unknown = 1'b1;
            return 1'b1;
        end
        n = live_entries(entry_cfg);
        pick_entry(focal_demand(sens_w, it.dist_mm, it.wsize, sc), n, wz, wf);
        pick_entry(focal_demand(sens_h, it.dist_mm, it.hsize, sc), n, hz, hf);
        res.zoom = (wz < hz) ? wz : hz;
        if (res.zoom < ZOOM_FLOOR)
            res.zoom = ZOOM_FLOOR;
        res.focus  = (wf < hf) ? wf : hf;
        held_focus = res.focus;
        return 1'b1;
    endfunction

    // mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    // unused fields of an item still carry random bits
    function automatic lens_item_t blank_item();
        lens_item_t it;
        it.cmd     = CMD_LOAD;
        it.idx     = 3'($urandom);
        it.efocal  = FOCAL_W'($urandom);
        it.ezoom   = ZOOM_W'($urandom);
        it.dist_mm = DIST_W'($urandom);
        it.wsize   = SIZE_W'($urandom);
        it.hsize   = SIZE_W'($urandom);
        it.scale   = SCALE_W'($urandom);
        return it;
    endfunction

    function automatic lens_item_t load_item(input logic [2:0] idx,
                                             input logic [FOCAL_W-1:0] f,
                                             input logic [ZOOM_W-1:0] z);
        lens_item_t it;
        it        = blank_item();
        it.cmd    = CMD_LOAD;
        it.idx    = idx;
        it.efocal = f;
        it.ezoom  = z;
        return it;
    endfunction

    function automatic lens_item_t query_item(input logic [DIST_W-1:0] dist_mm,
                                              input logic [SIZE_W-1:0] w,
                                              input logic [SIZE_W-1:0] h,
                                              input logic [SCALE_W-1:0] scale);
        lens_item_t it;
        it         = blank_item();
        it.cmd     = CMD_QUERY;
        it.dist_mm = dist_mm;
        it.wsize   = w;
        it.hsize   = h;
        it.scale   = scale;
        return it;
    endfunction

    function automatic void queue_item(input lens_item_t it);
        if (it.cmd == CMD_LOAD)
            plan_focal[it.idx] = it.efocal;
        pending_items = {pending_items, it};
        in_flight++;
    endfunction

    // rewrite the whole table in ascending order, equal neighbors allowed
    function automatic void queue_refill();
        int f;
        f = $urandom_range(0, 40);
        for (int i = 0; i < DEPTH; i++)
        begin
            queue_item(load_item(3'(i), FOCAL_W'(f), ZOOM_W'($urandom)));
            f = f + $urandom_range(0, 150);
            if (f > 1023)
                f = 1023;
        end
    endfunction

    // query whose width demand lands near a chosen table entry
    function automatic lens_item_t aimed_query();
        lens_item_t      it;
        longint unsigned q, reach;
        int              k;
        it = query_item('0, SIZE_W'($urandom_range(1, 300)), SIZE_W'($urandom_range(1, 300)),
                        SCALE_W'($urandom_range(1, 3)));
        if ($urandom_range(0, 1))
            it.hsize = it.wsize;
        k = $urandom_range(0, live_entries(entry_cfg) - 1);
        q = 64'(plan_focal[k]) * 16 + $urandom_range(0, 48);
        q = (q > 24) ? q - 24 : 0;
        if (sens_w == '0)
            reach = $urandom_range(0, int'(MAX_DIST));
        else
            reach = (q * 64'(UM_PER_MM) * 64'(it.wsize) * 64'(it.scale) + 64'(sens_w) * 16 - 1)
                    / (64'(sens_w) * 16);
        it.dist_mm = DIST_W'((reach > MAX_DIST) ? MAX_DIST : reach);
        return it;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_SENSOR_W: sens_w = val;
            CFG_SENSOR_H: sens_h = val;
            CFG_ENTRIES:  entry_cfg = val[3:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (in_flight != 0 || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // item sender
    always @(posedge clk or negedge rst_n)
    begin : item_send
        zoom_result_t got;
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tuser    <= 1'b0;
            s_tdata    <= '0;
            offer_live = 1'b0;
            send_gap   = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (predict_item(offer, got))
                    expected_results = {expected_results, got};
                in_flight--;
                offer_live = 1'b0;
            end
            if (!offer_live)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_items.size() != 0)
                begin
                    offer      = pending_items.pop_front();
                    offer_live = 1'b1;
                    send_gap   = pick_gap();
                end
            end
            s_tvalid <= offer_live;
            s_tuser  <= offer.cmd;
            // 83 field bits, padded to 88
            s_tdata  <= {5'd0, offer.scale, offer.hsize, offer.wsize, offer.dist_mm,
                         offer.ezoom, offer.efocal, offer.idx};
        end
    end

    // result receiver and checker
    always @(posedge clk or negedge rst_n)
    begin : result_check
        zoom_result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            take_gap = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    if (fault_count < REPORT_LIMIT)
                        $display("unexpected result: tdata %h tuser %b", m_tdata, m_tuser);
                    fault_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tdata[ZOOM_W-1:0] !== want.zoom ||
                        m_tdata[ZOOM_W +: FOCAL_W] !== want.focus ||
                        m_tuser !== want.unknown)
                    begin
                        if (fault_count < REPORT_LIMIT)
                            $display("result mismatch: zoom %0d/%0d focus %0d/%0d unknown %b/%b",
                                     want.zoom, m_tdata[ZOOM_W-1:0],
                                     want.focus, m_tdata[ZOOM_W +: FOCAL_W],
                                     want.unknown, m_tuser);
                        fault_count++;
                    end
                end
            end
            if (take_gap > 0)
            begin
                take_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                take_gap = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        lens_item_t         it;
        logic [SENS_W-1:0]  w, h;
        logic [3:0]         ne;
        int                 count, r;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset configuration: two entries, both sensors 3750
        queue_item(query_item(DIST_W'(5000), '0, SIZE_W'(100), SCALE_W'(1)));
        for (int i = 0; i < DEPTH; i++)
            queue_item(load_item(3'(i), FOCAL_W'(SEED_FOCAL[i]), ZOOM_W'(SEED_ZOOM[i])));
        queue_item(query_item('0, '1, '1, '1));
        queue_item(query_item('1, SIZE_W'(1), SIZE_W'(1), SCALE_W'(1)));
        queue_item(query_item(DIST_W'(100), '0, '0, '0));
        queue_item(query_item('1, '1, '0, '1));
        // zero scale behaves as one
        queue_item(query_item(DIST_W'(160), SIZE_W'(50), SIZE_W'(50), '0));
        // axes land on different entries
        queue_item(query_item(DIST_W'(100), SIZE_W'(50), SIZE_W'(25), SCALE_W'(1)));
        // demand below the first entry matches nothing
        queue_item(load_item(3'd0, FOCAL_W'(5), ZOOM_W'(3)));
        queue_item(query_item('0, SIZE_W'(7), SIZE_W'(9), SCALE_W'(2)));
        queue_item(query_item('1, '1, '1, '1));
        queue_item(query_item(DIST_W'(100), SIZE_W'(3), '0, SCALE_W'(4)));
        wait_idle();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: begin w = 16'd1;    h = 16'hFFFF; ne = 4'd8;  end
                1: begin w = 16'hFFFF; h = 16'd1;    ne = 4'd1;  end
                2: begin w = 16'd3750; h = 16'd2800; ne = 4'd0;  end
                3: begin w = 16'd0;    h = 16'd4800; ne = 4'hF;  end
                4: begin w = 16'd5600; h = 16'd3750; ne = 4'd9;  end
                default:
                begin
                    w  = SENS_W'($urandom_range(1, 65535));
                    h  = SENS_W'($urandom_range(1, 65535));
                    ne = 4'($urandom_range(1, DEPTH));
                end
            endcase
            write_reg(CFG_SENSOR_W, w);
            write_reg(CFG_SENSOR_H, h);
            write_reg(CFG_ENTRIES, {12'($urandom), ne});
            if (phase == 2)
                write_reg(CFG_UNUSED, 16'($urandom));
            calm  = (phase == 5);
            count = 0;
            while (count < PHASE_ITEMS)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                begin
                    queue_refill();
                    count += DEPTH;
                end
                else
                begin
                    if (r < 22)
                        it = load_item(3'($urandom), FOCAL_W'($urandom), ZOOM_W'($urandom));
                    else if (r < 30)
                    begin
                        it = query_item(DIST_W'($urandom), SIZE_W'($urandom),
                                        SIZE_W'($urandom), SCALE_W'($urandom));
                        case ($urandom_range(0, 2))
                            0: it.wsize = '0;
                            1: it.hsize = '0;
                            default: begin it.wsize = '0; it.hsize = '0; end
                        endcase
                    end
                    else if (r < 42)
                        it = query_item(DIST_W'($urandom), SIZE_W'($urandom),
                                        SIZE_W'($urandom), SCALE_W'($urandom));
                    else
                        it = aimed_query();
                    queue_item(it);
                    count++;
                end
            end
            wait_idle();
        end

        if (fault_count == 0 && expected_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
src/ftzs_pkg.sv
src/ftzs_div.sv
src/focal_table_zoom_select_core.sv
tb/testbench.sv
